/* rtl/lzss_pkg.sv */
// Shared types and constants of the LZSS stream decompressor.
package lzss_pkg;

    localparam int BYTE_W         = 8;
    localparam int CNT_W          = 32;
    localparam int FLAG_W         = 16;
    localparam int REMAIN_W       = 5;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam int WINDOW_DEPTH_DEF = 4096;

    // Write position starts this many entries below the top of the window.
    localparam int START_BACK     = 18;

    // A match of length n leaves n-1 bytes after the first; the nibble holds n-3.
    localparam logic [REMAIN_W-1:0] MATCH_EXTRA = REMAIN_W'(2);

    localparam logic [BYTE_W-1:0] FLAG_FILL    = 8'hFF;
    localparam logic [CNT_W-1:0]  LIMIT_RESET  = 32'hFFFF_FFFF;

    // Register indexes (byte address 4*index).
    localparam logic [0:0] REG_OUTPUT_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        PH_FLAG   = 2'd0,
        PH_TOKEN  = 2'd1,
        PH_MATCH2 = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        SQ_IDLE = 2'd0,
        SQ_READ = 2'd1,
        SQ_EMIT = 2'd2
    } seq_t;

endpackage

/* rtl/lzss_in_if.sv */
// Compressed input channel: one compressed byte per word.
interface lzss_in_if import lzss_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

/* rtl/lzss_out_if.sv */
// Decompressed output channel: one decoded byte per word.
interface lzss_out_if import lzss_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

/* rtl/lzss_window.sv */
// Sliding window memory: one write port, one read port with registered data.
module lzss_window import lzss_pkg::*; #(
    parameter int DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [BYTE_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [BYTE_W-1:0]        rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold the read word until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/lzss_stream_decompressor.sv */
// LZSS stream decompressor top level: token decoder, match sequencer, APB register.
//
// Takes one compressed byte per input word and emits decoded bytes, one per output word,
// with run_last on the final byte that an input word produces. A flag byte or the first
// byte of a match emits nothing. A literal is emitted and written to the window without a
// window read. In a match of length L (3 to 18) each copied byte goes through the single
// window memory as a registered read followed by a write at the write position; output stalls hold the emit.
// The input is not ready while a literal or match is being emitted. Window contents are
// masked by a fill count of entries written since the blob began, so there is no clearing
// pass after reset or after a word marked last. output_limit sits at byte address 0.
module lzss_stream_decompressor import lzss_pkg::*; #(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    lzss_in_if.sink               in_ch,
    lzss_out_if.source            out_ch
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam logic [AW-1:0] START_POS  = AW'(WINDOW_DEPTH - START_BACK);
    localparam logic [AW:0]   FILL_FULL  = (AW+1)'(WINDOW_DEPTH);

    seq_t                seq_state_reg, seq_state_next;
    phase_t              phase_reg, phase_next;
    logic [FLAG_W-1:0]   flag_reg, flag_next;
    logic [BYTE_W-1:0]   held_reg, held_next;
    logic [AW-1:0]       wp_reg, wp_next;
    logic [AW:0]         fill_reg, fill_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    limit_reg, limit_next;
    logic [AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [REMAIN_W-1:0] remain_reg, remain_next;
    logic [BYTE_W-1:0]   lit_reg, lit_next;
    logic                lit_mode_reg, lit_mode_next;
    logic                last_reg, last_next;
    logic                rd_valid_reg, rd_valid_next;
    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic                out_last_reg, out_last_next;

    logic                accept;
    logic                under_limit;
    logic                blob_clear;
    logic                out_load;
    logic [FLAG_W-1:0]   flag_shift;
    phase_t              phase_after;
    logic [AW-1:0]       rd_offset;
    logic [BYTE_W-1:0]   emit_byte;
    logic [BYTE_W-1:0]   win_rdata;
    logic                win_re;
    logic                win_we;
    logic                cfg_write;

    lzss_window #(
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (win_we),
        .waddr (wp_reg),
        .wdata (emit_byte),
        .re    (win_re),
        .raddr (rd_ptr_reg),
        .rdata (win_rdata)
    );

    // APB register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2:2] == REG_OUTPUT_LIMIT) ? limit_reg : '0;

    always_comb
    begin
        limit_next = limit_reg;
        if (cfg_write && (paddr[2:2] == REG_OUTPUT_LIMIT))
        begin
            limit_next = pwdata;
        end
    end

    assign in_ch.ready     = (seq_state_reg == SQ_IDLE);
    assign accept          = in_ch.valid && in_ch.ready;
    assign under_limit     = (count_reg < limit_reg);
    assign flag_shift      = {1'b0, flag_reg[FLAG_W-1:1]};
    assign phase_after     = flag_shift[8] ? PH_TOKEN : PH_FLAG;
    assign rd_offset       = rd_ptr_reg - START_POS;
    assign emit_byte       = lit_mode_reg ? lit_reg : (rd_valid_reg ? win_rdata : '0);
    assign out_load        = (seq_state_reg == SQ_EMIT) && (!out_valid_reg || out_ch.ready);
    assign win_we          = out_load;
    assign win_re          = (seq_state_reg == SQ_READ);

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.run_last = out_last_reg;

    always_comb
    begin
        seq_state_next = seq_state_reg;
        phase_next     = phase_reg;
        flag_next      = flag_reg;
        held_next      = held_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        remain_next    = remain_reg;
        lit_next       = lit_reg;
        lit_mode_next  = lit_mode_reg;
        last_next      = last_reg;
        rd_valid_next  = rd_valid_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        blob_clear     = 1'b0;

        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (seq_state_reg)
            SQ_IDLE:
            begin
                if (accept)
                begin
                    last_next = in_ch.in_last;
                    case (phase_reg)
                        PH_MATCH2:
                        begin
                            rd_ptr_next    = AW'({in_ch.in_byte[7:4], held_reg});
                            remain_next    = REMAIN_W'(in_ch.in_byte[3:0]) + MATCH_EXTRA;
                            lit_mode_next  = 1'b0;
                            flag_next      = flag_shift;
                            phase_next     = phase_after;
                            seq_state_next = SQ_READ;
                        end
                        PH_TOKEN:
                        begin
                            if (!under_limit)
                            begin
                                blob_clear = in_ch.in_last;
                            end
                            else if (flag_reg[0])
                            begin
                                lit_next       = in_ch.in_byte;
                                lit_mode_next  = 1'b1;
                                remain_next    = '0;
                                flag_next      = flag_shift;
                                phase_next     = phase_after;
                                seq_state_next = SQ_EMIT;
                            end
                            else
                            begin
                                held_next  = in_ch.in_byte;
                                phase_next = PH_MATCH2;
                                blob_clear = in_ch.in_last;
                            end
                        end
                        default:
                        begin
                            if (under_limit)
                            begin
                                flag_next  = {FLAG_FILL, in_ch.in_byte};
                                phase_next = PH_TOKEN;
                            end
                            blob_clear = in_ch.in_last;
                        end
                    endcase
                end
            end
            SQ_READ:
            begin
                // Entries not yet written in this blob read as zero.
                rd_valid_next  = ({1'b0, rd_offset} < fill_reg);
                seq_state_next = SQ_EMIT;
            end
            SQ_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = emit_byte;
                    out_last_next  = (remain_reg == '0);
                    wp_next        = wp_reg + 1'b1;
                    if (fill_reg != FILL_FULL)
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    if (count_reg != '1)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (remain_reg == '0)
                    begin
                        seq_state_next = SQ_IDLE;
                        blob_clear     = last_reg;
                    end
                    else
                    begin
                        remain_next    = remain_reg - 1'b1;
                        rd_ptr_next    = rd_ptr_reg + 1'b1;
                        seq_state_next = SQ_READ;
                    end
                end
            end
            default:
            begin
                seq_state_next = SQ_IDLE;
            end
        endcase

        // Drop all blob state after a word marked last.
        if (blob_clear)
        begin
            phase_next = PH_FLAG;
            flag_next  = '0;
            held_next  = '0;
            wp_next    = START_POS;
            fill_next  = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_state_reg <= SQ_IDLE;
            phase_reg     <= PH_FLAG;
            flag_reg      <= '0;
            held_reg      <= '0;
            wp_reg        <= START_POS;
            fill_reg      <= '0;
            count_reg     <= '0;
            limit_reg     <= LIMIT_RESET;
            remain_reg    <= '0;
            lit_mode_reg  <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_state_reg <= seq_state_next;
            phase_reg     <= phase_next;
            flag_reg      <= flag_next;
            held_reg      <= held_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            limit_reg     <= limit_next;
            remain_reg    <= remain_next;
            lit_mode_reg  <= lit_mode_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg   <= rd_ptr_next;
        lit_reg      <= lit_next;
        rd_valid_reg <= rd_valid_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("window fill count beyond window depth");

    a_idle_no_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_state_reg == SQ_IDLE) |-> (remain_reg == '0))
        else $error("match bytes left over while idle");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !blob_clear |=> (count_reg >= $past(count_reg)))
        else $error("output count dropped without a blob end");

    a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |-> !win_we)
        else $error("window written while output word still pending");

endmodule
